@@ sv/mtp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and codes for the timer pool: op codes, result kinds and the
// control/status groups passed between the sequencer and the slot update unit.
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_STOP    = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_POLL    = 3'd5;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_INVALID = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef struct packed {
        logic busy;
        logic periodic;
        logic critical;
    } timer_flags_t;

    // what the sequencer tells the head update unit about the current slot
    typedef struct packed {
        logic [2:0] op;
        logic [1:0] mode;
        logic       hit;        // head slot is the addressed timer_id
        logic       seek_free;  // start has not found a free slot yet
    } head_ctl_t;

    typedef struct packed {
        logic take;     // start allocated the head slot
        logic fire;     // head slot fired
        logic zero;     // query answer for the addressed slot
    } head_stat_t;

endpackage

@@ sv/mtp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_cell
// One stage of the timer ring: holds one slot and takes its neighbor's slot
// on every shift.
// ----------------------------------------------------------------------------
module mtp_cell #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     shift,
    input  mtp_pkg::timer_flags_t    d_flags,
    input  logic [COUNT_WIDTH-1:0]   d_count,
    input  logic [COUNT_WIDTH-1:0]   d_reload,
    output mtp_pkg::timer_flags_t    q_flags,
    output logic [COUNT_WIDTH-1:0]   q_count,
    output logic [COUNT_WIDTH-1:0]   q_reload
);

    mtp_pkg::timer_flags_t  flags_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] reload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg  <= '0;
            count_reg  <= '0;
            reload_reg <= '0;
        end else if (shift) begin
            flags_reg  <= d_flags;
            count_reg  <= d_count;
            reload_reg <= d_reload;
        end
    end

    assign q_flags  = flags_reg;
    assign q_count  = count_reg;
    assign q_reload = reload_reg;

endmodule

@@ sv/mtp_head.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_head
// Update unit at the head of the ring: applies the current request to the
// slot passing by and reports allocation, firing and query status.
// ----------------------------------------------------------------------------
module mtp_head #(
    parameter int COUNT_WIDTH = 32
) (
    input  mtp_pkg::head_ctl_t       ctl,
    input  logic [COUNT_WIDTH-1:0]   ticks,
    input  mtp_pkg::timer_flags_t    cur_flags,
    input  logic [COUNT_WIDTH-1:0]   cur_count,
    input  logic [COUNT_WIDTH-1:0]   cur_reload,
    output mtp_pkg::timer_flags_t    new_flags,
    output logic [COUNT_WIDTH-1:0]   new_count,
    output logic [COUNT_WIDTH-1:0]   new_reload,
    output mtp_pkg::head_stat_t      stat
);

    logic [COUNT_WIDTH-1:0] dec;
    logic                   fire;

    always_comb begin
        new_flags  = cur_flags;
        new_count  = cur_count;
        new_reload = cur_reload;
        stat       = '0;
        fire       = 1'b0;
        dec        = (cur_count == '0) ? '0 : cur_count - 1'b1;

        case (ctl.op)
            mtp_pkg::OP_START: begin
                if (!cur_flags.busy && ctl.seek_free) begin
                    new_flags.busy     = 1'b1;
                    new_flags.periodic = ctl.mode[1];
                    new_flags.critical = ctl.mode[0];
                    new_count          = ticks;
                    new_reload         = ticks;
                    stat.take          = 1'b1;
                end
            end
            mtp_pkg::OP_STOP: begin
                if (ctl.hit) begin
                    new_flags.busy = 1'b0;
                end
            end
            mtp_pkg::OP_RESTART: begin
                if (ctl.hit) begin
                    new_count = cur_reload;
                end
            end
            mtp_pkg::OP_QUERY: begin
                if (ctl.hit) begin
                    stat.zero = (cur_count == '0);
                end
            end
            mtp_pkg::OP_TICK: begin
                if (cur_flags.busy) begin
                    new_count = dec;
                    fire      = cur_flags.critical && (dec == '0);
                end
            end
            mtp_pkg::OP_POLL: begin
                fire = cur_flags.busy && !cur_flags.critical && (cur_count == '0);
            end
            default: begin
            end
        endcase

        // fired timer reloads if periodic, frees otherwise
        if (fire) begin
            if (cur_flags.periodic) begin
                new_count = cur_reload;
            end else begin
                new_flags.busy = 1'b0;
            end
        end
        stat.fire = fire;
    end

endmodule

@@ sv/multi_channel_timer_pool_core.sv @@
`timescale 1ns / 1ps
// Order: a request first rotates the whole ring past the head, then shows its last
//   result from the flush state, once the output register is free.
// Flow: a new request is taken only after the last one has flushed; the ring moves
//   one slot per cycle past the single head update unit. Output stalls hold it.
// Reset: synchronous, active low; every slot is cleared (free, count zero).
// ----------------------------------------------------------------------------
// multi_channel_timer_pool_core
// Bank of one-shot / periodic timers kept in a rotating ring of slot cells.
// ----------------------------------------------------------------------------
module multi_channel_timer_pool_core #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // timer_id[3:0], mode[5:4], tick_count[37:6], zero
    input  logic [2:0]  s_tuser,    // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // slot[3:0], expired[4], zero
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [4:0] NUM_SLOTS = 5'(NUM_TIMERS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [3:0]             id_reg, id_next;
    logic [1:0]             mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] ticks_reg, ticks_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [1:0]             pend_kind_reg, pend_kind_next;
    logic [3:0]             pend_slot_reg, pend_slot_next;
    logic                   pend_exp_reg, pend_exp_next;
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_kind_reg, m_kind_next;
    logic [3:0]             m_slot_reg, m_slot_next;
    logic                   m_exp_reg, m_exp_next;
    logic                   m_last_reg, m_last_next;

    logic                   shift;
    logic                   out_free;
    logic [2:0]             in_op;
    logic [3:0]             in_id;

    mtp_pkg::timer_flags_t  flags_q  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] reload_q [NUM_TIMERS];

    mtp_pkg::head_ctl_t     head_ctl;
    mtp_pkg::head_stat_t    head_stat;
    mtp_pkg::timer_flags_t  head_flags;
    logic [COUNT_WIDTH-1:0] head_count;
    logic [COUNT_WIDTH-1:0] head_reload;

    // ring: cell 0 is the head; the updated head slot re-enters at the tail
    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_ring
        if (k == NUM_TIMERS - 1) begin : g_tail
            mtp_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift    (shift),
                .d_flags  (head_flags),
                .d_count  (head_count),
                .d_reload (head_reload),
                .q_flags  (flags_q[k]),
                .q_count  (count_q[k]),
                .q_reload (reload_q[k])
            );
        end else begin : g_mid
            mtp_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift    (shift),
                .d_flags  (flags_q[k+1]),
                .d_count  (count_q[k+1]),
                .d_reload (reload_q[k+1]),
                .q_flags  (flags_q[k]),
                .q_count  (count_q[k]),
                .q_reload (reload_q[k])
            );
        end
    end

    always_comb begin
        head_ctl.op        = op_reg;
        head_ctl.mode      = mode_reg;
        head_ctl.hit       = (id_reg == 4'(idx_reg));
        head_ctl.seek_free = !found_reg;
    end

    mtp_head #(.COUNT_WIDTH(COUNT_WIDTH)) u_head (
        .ctl        (head_ctl),
        .ticks      (ticks_reg),
        .cur_flags  (flags_q[0]),
        .cur_count  (count_q[0]),
        .cur_reload (reload_q[0]),
        .new_flags  (head_flags),
        .new_count  (head_count),
        .new_reload (head_reload),
        .stat       (head_stat)
    );

    assign in_op    = s_tuser;
    assign in_id    = s_tdata[3:0];
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        mode_next       = mode_reg;
        ticks_next      = ticks_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        pend_exp_next   = pend_exp_reg;
        m_valid_next    = m_valid_reg;
        m_kind_next     = m_kind_reg;
        m_slot_next     = m_slot_reg;
        m_exp_next      = m_exp_reg;
        m_last_next     = m_last_reg;
        shift           = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = in_op;
                    id_next    = in_id;
                    mode_next  = s_tdata[5:4];
                    ticks_next = COUNT_WIDTH'(s_tdata[37:6]);
                    idx_next   = '0;
                    found_next = 1'b0;
                    // single-result requests hold their answer here until the scan ends
                    pend_valid_next = !(in_op inside {mtp_pkg::OP_TICK, mtp_pkg::OP_POLL});
                    pend_slot_next  = '0;
                    pend_exp_next   = 1'b0;
                    if ((in_op inside {mtp_pkg::OP_STOP, mtp_pkg::OP_RESTART,
                                       mtp_pkg::OP_QUERY}) && ({1'b0, in_id} < NUM_SLOTS)) begin
                        pend_kind_next = mtp_pkg::KIND_DONE;
                    end else begin
                        pend_kind_next = mtp_pkg::KIND_INVALID;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // a second firing needs the output register for the held one
                if (!(head_stat.fire && pend_valid_reg && !out_free)) begin
                    shift = 1'b1;
                    idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                    if (head_stat.take) begin
                        found_next     = 1'b1;
                        pend_kind_next = mtp_pkg::KIND_DONE;
                        pend_slot_next = 4'(idx_reg);
                    end
                    if (head_stat.zero) begin
                        pend_exp_next = 1'b1;
                    end
                    if (head_stat.fire) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = pend_kind_reg;
                            m_slot_next  = pend_slot_reg;
                            m_exp_next   = pend_exp_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = mtp_pkg::KIND_FIRED;
                        pend_slot_next  = 4'(idx_reg);
                        pend_exp_next   = 1'b0;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_kind_next = pend_kind_reg;
                        m_slot_next = pend_slot_reg;
                        m_exp_next  = pend_exp_reg;
                    end else begin
                        m_kind_next = mtp_pkg::KIND_NONE;
                        m_slot_next = '0;
                        m_exp_next  = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            found_reg      <= found_next;
            idx_reg        <= idx_next;
        end
        op_reg        <= op_next;
        id_reg        <= id_next;
        mode_reg      <= mode_next;
        ticks_reg     <= ticks_next;
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        pend_exp_reg  <= pend_exp_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_exp_reg     <= m_exp_next;
        m_last_reg    <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_exp_reg, m_slot_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ sv/mtp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_checker
// Port-level checks for the timer pool core, bound to the top level.
// ----------------------------------------------------------------------------
module mtp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // only fire events may be followed by more results of the same request
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != mtp_pkg::KIND_FIRED |-> m_tlast)
        else $error("non-fire result without last");

    a_expired_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tuser == mtp_pkg::KIND_DONE)
        else $error("expired set on a result that is not done");

    a_none_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mtp_pkg::KIND_NONE || m_tuser == mtp_pkg::KIND_INVALID)
        |-> m_tdata[3:0] == 4'd0)
        else $error("slot set on a result without a slot");

endmodule

bind multi_channel_timer_pool_core mtp_checker u_mtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
